// ===== hdl/ipiv_pkg.sv =====
// ----------------------------------------------------------------------------
// ipiv_pkg
// Shared types, constants and helpers of the icon-pack index validator.
// ----------------------------------------------------------------------------
`default_nettype none

package ipiv_pkg;

    localparam int MAX_ICONS      = 16;
    localparam int ID_CAPACITY    = 32;
    localparam int ICON_BYTES     = 4096;
    localparam int ICON_WIDTH     = 32;
    localparam int ICON_HEIGHT    = 32;
    localparam int MAX_PACK_BYTES = 1048576;

    localparam int HEADER_LEN = 16;
    localparam int ENTRY_LEN  = 40;
    localparam int OFFSET_AT  = 32;
    localparam int SIZE_AT    = 36;
    localparam int SCHEMA     = 1;

    localparam int POS_W  = 24;
    localparam int CFG_W  = 24;
    localparam int K_W    = 6;
    localparam int CELL_W = $clog2(MAX_ICONS + 1);
    localparam int IDX_W  = (ID_CAPACITY > 1) ? $clog2(ID_CAPACITY) : 1;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Result codes
    typedef enum logic [3:0] {
        ERR_NONE   = 4'd0,
        ERR_SIZE   = 4'd1,
        ERR_MAGIC  = 4'd2,
        ERR_SCHEMA = 4'd3,
        ERR_COUNT  = 4'd4,
        ERR_HEADER = 4'd5,
        ERR_IDENT  = 4'd6,
        ERR_DUP    = 4'd7,
        ERR_ENTRY  = 4'd8
    } err_t;

    // Broadcast to the identifier cells for one identifier byte
    typedef struct packed {
        logic              active;
        logic              first;
        logic [CELL_W-1:0] entry;
        logic [IDX_W-1:0]  col;
        logic [7:0]        data;
    } id_ctrl_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] r;
        unique case (idx)
            2'd0:    r = 8'h43;
            2'd1:    r = 8'h4D;
            2'd2:    r = 8'h43;
            default: r = 8'h31;
        endcase
        return r;
    endfunction

    function automatic logic id_char_ok(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h30 && b <= 8'h39) || b == 8'h2E || b == 8'h5F || b == 8'h2D;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/icon_pack_index_validator_core.sv =====
// ----------------------------------------------------------------------------
// icon_pack_index_validator_core
// The result item is registered: it appears in the cycle after the final index byte is accepted.
// Throughput: one index byte per cycle unless a result held back by m_tready stalls the input; the
// row of identifier cells compares each identifier byte against all earlier identifiers in the same cycle.
// Reset: rst_n clears all control state and the pack size register to zero.
// After each final byte the stream state returns to its reset value.
// ----------------------------------------------------------------------------
`default_nettype none

module icon_pack_index_validator_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // index bytes in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // last_byte
    // results out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [3:0] status, [4] pack_ok, [12:5] icon_total
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CW = ipiv_pkg::CFG_W;
    localparam int PW = ipiv_pkg::POS_W;

    logic [CW-1:0]  cfg_reg;
    logic [PW-1:0]  pos_reg, pos_next;
    logic [7:0]     count_reg, count_next;
    logic [31:0]    size_reg, size_next;
    ipiv_pkg::err_t fe_reg, fe_next;
    logic [31:0]    exp_reg, exp_next;
    logic [31:0]    word_reg, word_next;
    logic [5:0]     len_reg, len_next;
    logic           end_reg, end_next;
    logic [ipiv_pkg::K_W-1:0]    k_reg, k_next;
    logic [ipiv_pkg::CELL_W-1:0] i_reg, i_next;
    logic           mv_reg;
    logic [12:0]    mdata_reg, mdata_next;

    logic           acc;
    logic           in_dir;
    logic [PW-1:0]  dir_end;
    logic [7:0]     b;
    logic           dup_any;
    ipiv_pkg::id_ctrl_t ctrl;
    ipiv_pkg::err_t status;
    logic [32:0]    end_sum;

    assign acc      = s_tvalid & s_tready;
    assign s_tready = ~mv_reg | m_tready;
    assign b        = s_tdata;
    assign pready   = 1'b1;
    assign prdata   = (paddr == 3'd0) ? {{(32-CW){1'b0}}, cfg_reg} : 32'd0;
    assign m_tvalid = mv_reg;
    assign m_tdata  = {3'b000, mdata_reg};

    // Directory end: header plus count entries of forty bytes
    assign dir_end = PW'(ipiv_pkg::HEADER_LEN) + {{(PW-13){1'b0}}, count_reg, 5'b0}
                   + {{(PW-11){1'b0}}, count_reg, 3'b0};
    assign in_dir  = (pos_reg >= PW'(ipiv_pkg::HEADER_LEN)) &&
                     (fe_reg == ipiv_pkg::ERR_NONE) && (pos_reg < dir_end);

    // Drive the identifier cells
    always_comb
    begin
        ctrl.active = acc && in_dir && (k_reg < ipiv_pkg::K_W'(ipiv_pkg::ID_CAPACITY));
        ctrl.first  = (k_reg == '0);
        ctrl.entry  = i_reg;
        ctrl.col    = k_reg[ipiv_pkg::IDX_W-1:0];
        ctrl.data   = b;
    end

    ipiv_id_chain u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .dup_any (dup_any)
    );

    // Check each byte and build the result
    always_comb
    begin
        pos_next   = pos_reg;
        count_next = count_reg;
        size_next  = size_reg;
        fe_next    = fe_reg;
        exp_next   = exp_reg;
        word_next  = word_reg;
        len_next   = len_reg;
        end_next   = end_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        mdata_next = mdata_reg;
        status     = ipiv_pkg::ERR_NONE;
        end_sum    = '0;
        if (acc)
        begin
            if (pos_reg < PW'(ipiv_pkg::HEADER_LEN))
            begin
                unique case (pos_reg[3:0])
                    4'd0, 4'd1, 4'd2, 4'd3:
                    begin
                        if (b != ipiv_pkg::magic_byte(pos_reg[1:0]) &&
                            fe_next == ipiv_pkg::ERR_NONE)
                            fe_next = ipiv_pkg::ERR_MAGIC;
                    end
                    4'd4:
                    begin
                        if (b != 8'(ipiv_pkg::SCHEMA) && fe_next == ipiv_pkg::ERR_NONE)
                            fe_next = ipiv_pkg::ERR_SCHEMA;
                    end
                    4'd5:
                    begin
                        count_next = b;
                        if (b > 8'(ipiv_pkg::MAX_ICONS) && fe_next == ipiv_pkg::ERR_NONE)
                            fe_next = ipiv_pkg::ERR_COUNT;
                    end
                    4'd6:
                    begin
                        if (b != 8'(ipiv_pkg::ICON_WIDTH) && fe_next == ipiv_pkg::ERR_NONE)
                            fe_next = ipiv_pkg::ERR_HEADER;
                    end
                    4'd7:
                    begin
                        if (b != 8'(ipiv_pkg::ICON_HEIGHT) && fe_next == ipiv_pkg::ERR_NONE)
                            fe_next = ipiv_pkg::ERR_HEADER;
                    end
                    4'd8, 4'd9, 4'd10, 4'd11:
                    begin
                        size_next = {b, size_reg[31:8]};
                    end
                    default:
                    begin
                        if (b != 8'd0 && fe_next == ipiv_pkg::ERR_NONE)
                            fe_next = ipiv_pkg::ERR_HEADER;
                    end
                endcase
                // Size checks on the last header byte
                if (pos_reg[3:0] == 4'd15)
                begin
                    if (cfg_reg < CW'(ipiv_pkg::HEADER_LEN) ||
                        cfg_reg > CW'(ipiv_pkg::MAX_PACK_BYTES))
                        fe_next = ipiv_pkg::ERR_SIZE;
                    else if (fe_next == ipiv_pkg::ERR_NONE)
                    begin
                        if (size_reg != {{(32-CW){1'b0}}, cfg_reg} || dir_end > cfg_reg)
                            fe_next = ipiv_pkg::ERR_SIZE;
                        else
                            exp_next = 32'(dir_end);
                    end
                end
            end
            else if (in_dir)
            begin
                if (k_reg < ipiv_pkg::K_W'(ipiv_pkg::ID_CAPACITY))
                begin
                    if (k_reg == '0)
                    begin
                        len_next = 6'd0;
                        end_next = 1'b0;
                    end
                    if (!end_next)
                    begin
                        if (b == 8'd0)
                        begin
                            if (len_next == 6'd0)
                                fe_next = ipiv_pkg::ERR_IDENT;
                            else
                                end_next = 1'b1;
                        end
                        else if (!ipiv_pkg::id_char_ok(b))
                            fe_next = ipiv_pkg::ERR_IDENT;
                        else
                        begin
                            len_next = len_next + 6'd1;
                            if (len_next >= 6'(ipiv_pkg::ID_CAPACITY))
                                fe_next = ipiv_pkg::ERR_IDENT;
                        end
                    end
                    else if (b != 8'd0)
                        fe_next = ipiv_pkg::ERR_IDENT;
                    if (k_reg == ipiv_pkg::K_W'(ipiv_pkg::ID_CAPACITY - 1) &&
                        fe_next == ipiv_pkg::ERR_NONE && dup_any)
                        fe_next = ipiv_pkg::ERR_DUP;
                end
                else if (k_reg >= ipiv_pkg::K_W'(ipiv_pkg::OFFSET_AT))
                begin
                    word_next = {b, word_reg[31:8]};
                    end_sum   = {1'b0, exp_reg} + {1'b0, word_next};
                    if (k_reg == ipiv_pkg::K_W'(ipiv_pkg::OFFSET_AT + 3))
                    begin
                        if (word_next != exp_reg)
                            fe_next = ipiv_pkg::ERR_ENTRY;
                    end
                    else if (k_reg == ipiv_pkg::K_W'(ipiv_pkg::SIZE_AT + 3))
                    begin
                        if (word_next != 32'(ipiv_pkg::ICON_BYTES) ||
                            end_sum > {{(33-CW){1'b0}}, cfg_reg})
                            fe_next = ipiv_pkg::ERR_ENTRY;
                        else
                            exp_next = exp_reg + 32'(ipiv_pkg::ICON_BYTES);
                    end
                end
                // Advance the entry column and index
                if (k_reg == ipiv_pkg::K_W'(ipiv_pkg::ENTRY_LEN - 1))
                begin
                    k_next = '0;
                    i_next = i_reg + 1'b1;
                end
                else
                    k_next = k_reg + 1'b1;
            end
            if (pos_reg != ipiv_pkg::POS_MAX)
                pos_next = pos_reg + 1'b1;
            // Final byte: pick the status and clear the stream state
            if (s_tlast)
            begin
                priority if (pos_reg < PW'(ipiv_pkg::HEADER_LEN - 1))
                    status = ipiv_pkg::ERR_SIZE;
                else if (fe_next == ipiv_pkg::ERR_SIZE || fe_next == ipiv_pkg::ERR_MAGIC ||
                         fe_next == ipiv_pkg::ERR_SCHEMA || fe_next == ipiv_pkg::ERR_COUNT ||
                         fe_next == ipiv_pkg::ERR_HEADER)
                    status = fe_next;
                else if ({1'b0, pos_reg} + 1'b1 < {1'b0, dir_end})
                    status = ipiv_pkg::ERR_SIZE;
                else if (fe_next != ipiv_pkg::ERR_NONE)
                    status = fe_next;
                else if (exp_next != {{(32-CW){1'b0}}, cfg_reg})
                    status = ipiv_pkg::ERR_ENTRY;
                else
                    status = ipiv_pkg::ERR_NONE;
                mdata_next = {(status == ipiv_pkg::ERR_NONE) ? count_reg : 8'd0,
                              status == ipiv_pkg::ERR_NONE, status};
                pos_next   = '0;
                count_next = '0;
                size_next  = '0;
                fe_next    = ipiv_pkg::ERR_NONE;
                exp_next   = '0;
                word_next  = '0;
                len_next   = '0;
                end_next   = 1'b0;
                k_next     = '0;
                i_next     = '0;
            end
        end
    end

    // Hold stream state, result and pack size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= '0;
            pos_reg   <= '0;
            count_reg <= '0;
            size_reg  <= '0;
            fe_reg    <= ipiv_pkg::ERR_NONE;
            exp_reg   <= '0;
            word_reg  <= '0;
            len_reg   <= '0;
            end_reg   <= 1'b0;
            k_reg     <= '0;
            i_reg     <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr == 3'd0)
                cfg_reg <= pwdata[CW-1:0];
            pos_reg   <= pos_next;
            count_reg <= count_next;
            size_reg  <= size_next;
            fe_reg    <= fe_next;
            exp_reg   <= exp_next;
            word_reg  <= word_next;
            len_reg   <= len_next;
            end_reg   <= end_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            if (acc && s_tlast)
                mv_reg <= 1'b1;
            else if (m_tready)
                mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        mdata_reg <= mdata_next;
    end

    a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
        (mv_reg && !mdata_reg[4]) |-> (mdata_reg[12:5] == 8'd0))
        else $error("icon total set on a failed pack");
    a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        mv_reg |-> (mdata_reg[4] == (mdata_reg[3:0] == ipiv_pkg::ERR_NONE)))
        else $error("pack_ok disagrees with status");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && s_tlast) |=> (pos_reg == '0 && fe_reg == ipiv_pkg::ERR_NONE))
        else $error("stream state not cleared after final byte");
    a_col: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg < ipiv_pkg::K_W'(ipiv_pkg::ENTRY_LEN))
        else $error("entry column out of range");

endmodule

`default_nettype wire

// ===== hdl/ipiv_id_cell.sv =====
// ----------------------------------------------------------------------------
// ipiv_id_cell
// One identifier cell: holds one directory identifier and its match flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ipiv_id_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ipiv_pkg::id_ctrl_t ctrl,
    input  wire logic [ipiv_pkg::CELL_W-1:0] cell_id,
    input  wire logic               match_in,
    output logic                    match_out
);

    logic [7:0] id_mem [ipiv_pkg::ID_CAPACITY];
    logic       flag_reg;
    logic       flag_next;
    logic       flag_base;
    logic       hit;

    // Compare the stored byte at this column with the incoming byte
    assign hit       = (id_mem[ctrl.col] == ctrl.data);
    assign flag_base = ctrl.first ? (cell_id < ctrl.entry) : flag_reg;
    assign flag_next = ctrl.active ? (flag_base & hit) : flag_reg;

    // Pass the duplicate indication down the row
    assign match_out = match_in | (ctrl.active & flag_next);

    // Store the identifier byte of the current entry
    always_ff @(posedge clk)
    begin
        if (ctrl.active && ctrl.entry == cell_id)
        begin
            id_mem[ctrl.col] <= ctrl.data;
        end
    end

    // Hold the match flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else
        begin
            flag_reg <= flag_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ipiv_id_chain.sv =====
// ----------------------------------------------------------------------------
// ipiv_id_chain
// Row of identifier cells with a chained duplicate indication.
// ----------------------------------------------------------------------------
`default_nettype none

module ipiv_id_chain (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ipiv_pkg::id_ctrl_t ctrl,
    output logic                    dup_any
);

    logic [ipiv_pkg::MAX_ICONS:0] link;

    assign link[0] = 1'b0;

    for (genvar c = 0; c < ipiv_pkg::MAX_ICONS; c++)
    begin : g_cell
        ipiv_id_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .cell_id   (ipiv_pkg::CELL_W'(c)),
            .match_in  (link[c]),
            .match_out (link[c+1])
        );
    end

    assign dup_any = link[ipiv_pkg::MAX_ICONS];

endmodule

`default_nettype wire
